// ===== src/bounded_set_span_tracker_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Span tracker assertion macros
// Shared assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SET_SPAN_TRACKER_UNIT_DEFINES_SVH
`define BOUNDED_SET_SPAN_TRACKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define BSST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BSST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BSST_ASSERT_NOW(lbl, ante, cons, msg)
`define BSST_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/bsst_pkg.sv =====
// ----------------------------------------------------------------------------
// Span tracker package
// Shared constants and types of the bounded set span tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package bsst_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 1024;
  localparam int unsigned VAL_W           = 32;
  localparam int unsigned CAP_W           = 11;
  localparam logic [CAP_W-1:0] CAP_RESET  = 11'd1024;

  typedef enum logic [1:0] {
    STAT_ADDED = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ===== src/bounded_set_span_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// Bounded set span tracker
// Keeps a bounded store of distinct signed values and reports the smallest
// gap and the full span of the stored set with every inserted value.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | input     | in_value (signed 32)
//  out_    | output    | out_status, out_span_valid, out_shortest_span,
//          |           | out_longest_span
//  cfg_    | input     | cfg_capacity (11 bits, always ready)
//
// One beat at a time: an item is accepted in idle, the scan state then reads
// every filled entry through the single read port of the value store, which is
// scanned one entry a cycle, and the done state settles the item.
// Reset needs no clearing pass; entries above the fill count are never read.
// A new beat is taken while the previous result still waits on out_ready;
// the store is written back only once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_set_span_tracker_unit_defines.svh"

module bounded_set_span_tracker_unit #(
  parameter int unsigned MAX_ENTRIES = bsst_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [bsst_pkg::VAL_W-1:0] in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic             [1:0]                 out_status,
  output logic                                   out_span_valid,
  output logic             [bsst_pkg::VAL_W-1:0] out_shortest_span,
  output logic             [bsst_pkg::VAL_W-1:0] out_longest_span,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic        [bsst_pkg::CAP_W-1:0] cfg_capacity
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned VW = bsst_pkg::VAL_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] TWO     = CW'(2);

  bsst_pkg::state_t state_r, state_nxt;

  logic [bsst_pkg::CAP_W-1:0] cap_r;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              idx_r;
  logic                       rvalid_r;
  logic signed [VW-1:0]       val_r;
  logic                       dup_r;
  logic [VW-1:0]              run_min_r;
  logic [VW-1:0]              min_gap_r, min_gap_nxt;
  logic signed [VW-1:0]       small_r, small_nxt;
  logic signed [VW-1:0]       large_r, large_nxt;

  logic                       out_valid_r;
  bsst_pkg::status_t          out_status_r, status_nxt;
  logic                       out_span_valid_r;
  logic [VW-1:0]              out_short_r;
  logic [VW-1:0]              out_long_r;

  logic                       in_fire;
  logic                       rd_en;
  logic signed [VW-1:0]       rd_data;
  logic [VW-1:0]              gap_abs;
  logic                       done_fire;
  logic                       full;
  logic                       add;
  logic                       mem_we;

  assign in_ready  = (state_r == bsst_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign rd_en     = (state_r == bsst_pkg::ST_SCAN) && (idx_r < count_r);
  assign done_fire = (state_r == bsst_pkg::ST_DONE) && (!out_valid_r || out_ready);

  // capacity above the store depth saturates at the depth
  assign full   = (32'(count_r) >= 32'(cap_r)) || (count_r >= MAX_CNT);
  assign add    = !dup_r && !full;
  assign mem_we = done_fire && add;

  bsst_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (val_r),
    .rd_en   (rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  // |a-b| always fits 32 bits unsigned
  assign gap_abs = (val_r >= rd_data) ? VW'(val_r - rd_data) : VW'(rd_data - val_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsst_pkg::ST_IDLE: if (in_fire) state_nxt = bsst_pkg::ST_SCAN;
      bsst_pkg::ST_SCAN: if (!rd_en && !rvalid_r) state_nxt = bsst_pkg::ST_DONE;
      bsst_pkg::ST_DONE: if (done_fire) state_nxt = bsst_pkg::ST_IDLE;
      default:           state_nxt = bsst_pkg::ST_IDLE;
    endcase
  end

  // settle the item against the scan results
  always_comb begin
    status_nxt  = bsst_pkg::STAT_ADDED;
    min_gap_nxt = min_gap_r;
    small_nxt   = small_r;
    large_nxt   = large_r;
    count_nxt   = count_r;
    if (dup_r) begin
      status_nxt = bsst_pkg::STAT_DUP;
    end else if (full) begin
      status_nxt = bsst_pkg::STAT_FULL;
    end else begin
      count_nxt = count_r + CW'(1);
      if (run_min_r < min_gap_r) min_gap_nxt = run_min_r;
      if ((count_r == '0) || (val_r < small_r)) small_nxt = val_r;
      if ((count_r == '0) || (val_r > large_r)) large_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsst_pkg::ST_IDLE;
      cap_r       <= bsst_pkg::CAP_RESET;
      count_r     <= '0;
      rvalid_r    <= 1'b0;
      min_gap_r   <= '1;
      small_r     <= '0;
      large_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rvalid_r    <= rd_en;
      out_valid_r <= done_fire || (out_valid_r && !out_ready);
      if (cfg_valid && cfg_ready) cap_r <= cfg_capacity;
      if (done_fire) begin
        count_r     <= count_nxt;
        min_gap_r   <= min_gap_nxt;
        small_r     <= small_nxt;
        large_r     <= large_nxt;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      val_r     <= in_value;
      idx_r     <= '0;
      dup_r     <= 1'b0;
      run_min_r <= '1;
    end else begin
      if (rd_en) idx_r <= idx_r + CW'(1);
      if (rvalid_r) begin
        if (rd_data == val_r) dup_r <= 1'b1;
        if (gap_abs < run_min_r) run_min_r <= gap_abs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_status_r     <= status_nxt;
      out_span_valid_r <= (count_nxt >= TWO);
      out_short_r      <= (count_nxt >= TWO) ? min_gap_nxt : '0;
      out_long_r       <= (count_nxt >= TWO) ? VW'(large_nxt - small_nxt) : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_span_valid    = out_span_valid_r;
  assign out_shortest_span = out_short_r;
  assign out_longest_span  = out_long_r;

  `BSST_ASSERT_NOW(a_count_bound, 1'b1, count_r <= MAX_CNT, "fill count above store depth")
  `BSST_ASSERT_NOW(a_wr_no_rd, mem_we, !rd_en, "store write overlaps a scan read")
  `BSST_ASSERT_NXT(a_add_grows, mem_we, count_r == $past(count_r) + CW'(1), "insert lost")
  `BSST_ASSERT_NOW(a_span_cnt, out_valid_r && out_span_valid_r, count_r >= TWO, "span without pair")
  `BSST_ASSERT_NOW(a_in_idle, in_fire, !rvalid_r, "beat taken during scan")

endmodule

`default_nettype wire

// ===== src/bsst_ram.sv =====
// ----------------------------------------------------------------------------
// Span tracker RAM
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bsst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span tracker testbench
// Feeds values into the bounded set span tracker over its valid/ready
// channels, runs a bit-exact predictor of the distinct-value store, and checks
// every result beat field by field. It covers a directed run at the capacity
// extremes, then random traffic over several capacity settings, with random
// gaps on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int IDLE_PCT       = 22;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] MINUS_ONE = 32'hFFFF_FFFF;

  typedef struct {
    bsst_pkg::status_t status;
    logic              span_valid;
    logic [31:0]       shortest;
    logic [31:0]       longest;
  } span_result_t;

  // Predicts one result per offered value and checks result beats in order.
  class set_span_predictor;
    logic [31:0]  stored_vals[$];
    span_result_t due_spans[$];
    int unsigned  cap_setting;
    logic [31:0]  gap_min;
    logic [31:0]  lo_val;
    logic [31:0]  hi_val;
    int           errors;

    function new();
      cap_setting = bsst_pkg::CAP_RESET;
      gap_min     = '1;
      lo_val      = '0;
      hi_val      = '0;
      errors      = 0;
    endfunction

    function void set_capacity(logic [bsst_pkg::CAP_W-1:0] c);
      cap_setting = c;
    endfunction

    function void offer_value(logic [31:0] v);
      span_result_t exp;
      bit           dup;
      int unsigned  limit;
      logic [31:0]  gap;
      dup = 1'b0;
      foreach (stored_vals[i])
        if (stored_vals[i] == v) dup = 1'b1;
      limit = (cap_setting < bsst_pkg::MAX_ENTRIES_DEF) ? cap_setting :
              bsst_pkg::MAX_ENTRIES_DEF;
      if (dup) begin
        exp.status = bsst_pkg::STAT_DUP;
      end else if (stored_vals.size() >= limit) begin
        exp.status = bsst_pkg::STAT_FULL;
      end else begin
        exp.status = bsst_pkg::STAT_ADDED;
        foreach (stored_vals[i]) begin
          // modulo 32-bit difference is exact for the true distance
          if ($signed(v) >= $signed(stored_vals[i])) gap = v - stored_vals[i];
          else gap = stored_vals[i] - v;
          if (gap < gap_min) gap_min = gap;
        end
        if (stored_vals.size() == 0) begin
          lo_val = v;
          hi_val = v;
        end else begin
          if ($signed(v) < $signed(lo_val)) lo_val = v;
          if ($signed(v) > $signed(hi_val)) hi_val = v;
        end
        stored_vals = {stored_vals, v};
      end
      exp.span_valid = (stored_vals.size() >= 2);
      exp.shortest   = exp.span_valid ? gap_min : '0;
      exp.longest    = exp.span_valid ? hi_val - lo_val : '0;
      due_spans = {due_spans, exp};
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_span(logic [1:0] st, logic sv, logic [31:0] sh, logic [31:0] lg);
      span_result_t exp;
      if (due_spans.size() == 0) begin
        report($sformatf("result beat with nothing expected (status %0d)", st));
      end else begin
        exp = due_spans.pop_front();
        if (st !== exp.status)
          report($sformatf("status %0d, expected %0d", st, exp.status));
        if (sv !== exp.span_valid)
          report($sformatf("span_valid %0b, expected %0b", sv, exp.span_valid));
        if (sh !== exp.shortest)
          report($sformatf("shortest_span %h, expected %h", sh, exp.shortest));
        if (lg !== exp.longest)
          report($sformatf("longest_span %h, expected %h", lg, exp.longest));
      end
    endtask
  endclass

  logic                        clk          = 1'b0;
  logic                        rst_n        = 1'b0;
  logic                        in_valid     = 1'b0;
  logic                        in_ready;
  logic [31:0]                 in_value     = '0;
  logic                        out_valid;
  logic                        out_ready    = 1'b0;
  logic [1:0]                  out_status;
  logic                        out_span_valid;
  logic [31:0]                 out_shortest_span;
  logic [31:0]                 out_longest_span;
  logic                        cfg_valid    = 1'b0;
  logic                        cfg_ready;
  logic [bsst_pkg::CAP_W-1:0]  cfg_capacity = '0;

  bit                quiet        = 1'b0;
  int                stall_cycles = 0;
  set_span_predictor tracker      = new();

  bounded_set_span_tracker_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_span_valid    (out_span_valid),
    .out_shortest_span (out_shortest_span),
    .out_longest_span  (out_longest_span),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_capacity      (cfg_capacity)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: check each beat, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        tracker.check_span(out_status, out_span_valid, out_shortest_span, out_longest_span);
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_value(input logic [31:0] v);
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.offer_value(v);
  endtask

  // waits for every outstanding result, then writes the capacity register
  task automatic write_capacity(input logic [bsst_pkg::CAP_W-1:0] c);
    in_valid <= 1'b0;
    while (tracker.due_spans.size() != 0) @(posedge clk);
    cfg_valid    <= 1'b1;
    cfg_capacity <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.set_capacity(c);
  endtask

  // duplicates, near neighbours for small gaps, extremes, and wide random values
  function automatic logic [31:0] pick_value();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    n = tracker.stored_vals.size();
    if (n != 0 && r < 20) return tracker.stored_vals[$urandom_range(n - 1)];
    if (n != 0 && r < 45)
      return tracker.stored_vals[$urandom_range(n - 1)] + $urandom_range(8) - 4;
    if (r < 50) begin
      case ($urandom_range(3))
        0:       return MOST_NEG;
        1:       return MOST_POS;
        2:       return MINUS_ONE;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_value(pick_value());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store, zero capacity: everything is full
    write_capacity(11'd0);
    send_value(MOST_NEG);
    send_value(MOST_POS);
    send_value('0);

    // single entry: no span yet
    write_capacity(11'd1);
    send_value(MOST_NEG);
    send_value(MOST_NEG);
    send_value('0);

    // both extremes stored: widest possible gap and span
    write_capacity(11'd2);
    send_value(MOST_POS);
    send_value(MOST_POS);
    send_value('0);

    // capacity below fill count: duplicates still seen, new values full
    write_capacity(11'd1);
    send_value(MOST_NEG);
    send_value(32'd1);

    // above the store size, saturates
    write_capacity(11'd2047);
    send_value(MINUS_ONE);
    send_value('0);
    send_value(32'd1);
    send_value(MINUS_ONE);
    send_value(32'h7FFF_FFFE);
    send_value(32'h8000_0001);

    send_random(250);

    // tight capacity so the store fills during the phase
    write_capacity(bsst_pkg::CAP_W'(tracker.stored_vals.size() + 12));
    send_random(150);

    write_capacity(bsst_pkg::CAP_RESET);
    quiet = 1'b1;
    send_random(60);
    quiet = 1'b0;
    send_random(120);

    in_valid <= 1'b0;
    while (tracker.due_spans.size() != 0) @(posedge clk);
    repeat (tracker.stored_vals.size() + 8) @(posedge clk);
    if (tracker.due_spans.size() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.due_spans.size()));

    if (tracker.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
